### src/lpg_pkg.sv
// Package for the low-pass gate sample step block.
// Holds fixed field widths, Q1.15 constants and configuration register indexes.
// No dependencies.
package lpg_pkg;

    localparam int LEVEL_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int HPC_W      = 15;
    localparam int QUOT_W     = 15;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] ONE_Q15   = 16'd32768;
    localparam logic [LEVEL_W-1:0] TENTH_Q15 = 16'd3277;
    localparam logic [14:0]        HALF_Q15  = 15'd16384;
    localparam logic [HPC_W-1:0]   HPC_RESET = 15'd32440;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS_ENABLE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_OFFSET     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS_COEFF  = 8'd3;

    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [GAIN_W-1:0]  t_gain;

endpackage

### src/lpg_in_if.sv
// Input channel of the low-pass gate: level and sample per item.
// Depends on lpg_pkg.
interface lpg_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic [lpg_pkg::LEVEL_W-1:0]    level;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output level, output sample_in, input ready);
    modport sink   (input valid, input level, input sample_in, output ready);
endinterface

### src/lpg_out_if.sv
// Output channel of the low-pass gate: processed sample and clip flag per item.
// No dependencies.
interface lpg_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

### src/lpg_cfg_if.sv
// Configuration write channel of the low-pass gate: register index and data.
// Depends on lpg_pkg.
interface lpg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lpg_pkg::CFG_IDX_W-1:0]  index;
    logic [lpg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/lpg_div.sv
// Serial restoring divider for the filter gain level*32768/(0.1+level), rounded.
// One quotient bit per cycle. Depends on lpg_pkg.
module lpg_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lpg_pkg::LEVEL_W-1:0] i_level,
    output logic                        o_done,
    output logic [lpg_pkg::QUOT_W-1:0]  o_quot
);
    logic [lpg_pkg::LEVEL_W-1:0] r_den, n_den;
    logic [lpg_pkg::LEVEL_W-1:0] r_rem, n_rem;
    logic [lpg_pkg::QUOT_W-1:0]  r_num, n_num;
    logic [lpg_pkg::QUOT_W-1:0]  r_quot, n_quot;
    logic [3:0]                  r_cnt, n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [lpg_pkg::LEVEL_W:0]   w_trial;
    logic [lpg_pkg::LEVEL_W:0]   w_diff;
    logic                        w_ge;
    logic [lpg_pkg::LEVEL_W-1:0] w_den_start;

    assign w_den_start = lpg_pkg::TENTH_Q15 + i_level;
    assign w_trial     = {r_rem, r_num[lpg_pkg::QUOT_W-1]};
    assign w_ge        = (w_trial >= {1'b0, r_den});
    assign w_diff      = w_trial - {1'b0, r_den};

    always_comb begin
        n_den  = r_den;
        n_rem  = r_rem;
        n_num  = r_num;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_den  = w_den_start;
            n_rem  = i_level;
            n_num  = w_den_start[lpg_pkg::LEVEL_W-1:1];
            n_quot = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[lpg_pkg::LEVEL_W-1:0] : w_trial[lpg_pkg::LEVEL_W-1:0];
            n_quot = {r_quot[lpg_pkg::QUOT_W-2:0], w_ge};
            n_num  = {r_num[lpg_pkg::QUOT_W-2:0], 1'b0};
            n_cnt  = r_cnt + 4'd1;
            if (r_cnt == 4'(lpg_pkg::QUOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

### src/lpg_mul.sv
// Shared multiplier: unsigned Q.15 factor times signed state operand, registered product.
// Depends on lpg_pkg.
module lpg_mul #(
    parameter int BW = 26
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [lpg_pkg::GAIN_W-1:0] i_a,
    input  logic signed [BW-1:0]       i_b,
    output logic signed [BW+lpg_pkg::GAIN_W:0] o_prod
);
    logic signed [BW+lpg_pkg::GAIN_W:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= $signed({1'b0, i_a}) * i_b;
        end
    end

    assign o_prod = r_prod;
endmodule

### src/low_pass_gate_sample_step.sv
// Low-pass gate, one audio sample per item: level-driven one-pole low-pass, level gain,
// optional one-pole high-pass, saturation to the state range.
// Depends on lpg_pkg, lpg_in_if, lpg_out_if, lpg_cfg_if, lpg_div and lpg_mul.
//
// An item passes the divide step S_DIV (filter mode only), then the multiply and round-and-add
// steps S_M1/S_A1, S_M2/S_A2 and, with the high-pass on, S_M3/S_A3, to S_DONE. In filter mode
// the serial divider yields one quotient bit per cycle; the rest is the single shared multiplier,
// used for the low-pass step, the gain and the high-pass feedback in turn, each followed by a
// round and add step. S_DONE waits while the output register holds an untaken result. A new
// item is taken once the previous one has moved into the output register, even if that result
// has not yet been taken. Configuration writes are always ready.
module low_pass_gate_sample_step #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 24
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lpg_in_if.sink    i_in,
    lpg_out_if.source o_out,
    lpg_cfg_if.sink   i_cfg
);
    localparam int SW = SAMPLE_WIDTH;
    localparam int ST = STATE_WIDTH;
    localparam int BW = ST + 2;
    localparam int PW = BW + lpg_pkg::GAIN_W + 1;
    localparam int RW = PW - 15;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_A1   = 4'd3;
    localparam logic [3:0] S_M2   = 4'd4;
    localparam logic [3:0] S_A2   = 4'd5;
    localparam logic [3:0] S_M3   = 4'd6;
    localparam logic [3:0] S_A3   = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] r_state, n_state;

    logic                        r_filter_mode;
    logic                        r_hp_enable;
    logic [lpg_pkg::GAIN_W-1:0]  r_gain_offset;
    logic [lpg_pkg::HPC_W-1:0]   r_hp_coeff;

    logic signed [ST-1:0]        r_last_lp, n_last_lp;
    logic signed [ST-1:0]        r_last_out, n_last_out;
    logic signed [ST-1:0]        r_x, n_x;
    lpg_pkg::t_level             r_coef, n_coef;
    lpg_pkg::t_gain              r_gain, n_gain;
    logic signed [BW-1:0]        r_lp1, n_lp1;
    logic signed [ST-1:0]        r_lp, n_lp;
    logic signed [ST-1:0]        r_hp, n_hp;
    logic                        r_clip, n_clip;

    logic                        r_out_valid, n_out_valid;
    logic signed [SW-1:0]        r_out_sample, n_out_sample;
    logic                        r_out_clip, n_out_clip;

    logic                        w_in_acc;
    lpg_pkg::t_level             w_level;
    lpg_pkg::t_gain              w_offset;
    logic [lpg_pkg::LEVEL_W:0]   w_gate_sum;
    logic signed [ST-1:0]        w_x_in;
    logic signed [SW-1:0]        w_hp_out;

    logic                        w_div_start;
    logic                        w_div_done;
    logic [lpg_pkg::QUOT_W-1:0]  w_quot;

    logic                        w_mul_en;
    logic [lpg_pkg::GAIN_W-1:0]  w_mul_a;
    logic signed [BW-1:0]        w_mul_b;
    logic signed [PW-1:0]        w_prod;
    logic signed [PW-1:0]        w_psum;
    logic signed [RW-1:0]        w_rnd;
    logic signed [RW-1:0]        w_hi;
    logic signed [RW-1:0]        w_lo;
    logic signed [RW-1:0]        w_hp_sum;

    // Sample <-> state format conversion
    generate
        if (ST > SW) begin : g_up
            assign w_x_in   = {i_in.sample_in, {(ST-SW){1'b0}}};
            assign w_hp_out = r_hp[ST-1:ST-SW];
        end else if (ST == SW) begin : g_same
            assign w_x_in   = i_in.sample_in;
            assign w_hp_out = r_hp;
        end else begin : g_down
            assign w_x_in   = i_in.sample_in[SW-1:SW-ST];
            assign w_hp_out = {r_hp, {(SW-ST){1'b0}}};
        end
    endgenerate

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_level    = (i_in.level > lpg_pkg::ONE_Q15) ? lpg_pkg::ONE_Q15 : i_in.level;
    assign w_offset   = (r_gain_offset > lpg_pkg::ONE_Q15) ? lpg_pkg::ONE_Q15 : r_gain_offset;
    assign w_gate_sum = {1'b0, lpg_pkg::ONE_Q15} + {1'b0, w_level};
    assign w_div_start = w_in_acc && r_filter_mode;

    lpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_level (w_level),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = r_coef;
        w_mul_b  = BW'(r_x) - BW'(r_last_lp);
        case (r_state)
            S_M1: begin
                w_mul_en = 1'b1;
            end
            S_M2: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_gain;
                w_mul_b  = r_lp1;
            end
            S_M3: begin
                w_mul_en = 1'b1;
                w_mul_a  = lpg_pkg::GAIN_W'(r_hp_coeff);
                w_mul_b  = BW'(r_last_out);
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    lpg_mul #(.BW(BW)) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Round half up, then saturate bounds of the state range
    assign w_psum   = w_prod + $signed({{(PW-15){1'b0}}, lpg_pkg::HALF_Q15});
    assign w_rnd    = w_psum[PW-1:15];
    assign w_hi     = {{(RW-ST+1){1'b0}}, {(ST-1){1'b1}}};
    assign w_lo     = ~w_hi;
    assign w_hp_sum = RW'(r_lp) - RW'(r_last_lp) + w_rnd;

    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_coef       = r_coef;
        n_gain       = r_gain;
        n_lp1        = r_lp1;
        n_lp         = r_lp;
        n_hp         = r_hp;
        n_clip       = r_clip;
        n_last_lp    = r_last_lp;
        n_last_out   = r_last_out;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_clip   = r_out_clip;
        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_x    = w_x_in;
                    n_clip = 1'b0;
                    if (r_filter_mode) begin
                        n_coef  = w_level;
                        n_gain  = '0;
                        n_state = S_DIV;
                    end else begin
                        n_coef  = w_gate_sum[lpg_pkg::LEVEL_W:1];
                        n_gain  = w_level;
                        n_state = S_M1;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_gain  = lpg_pkg::GAIN_W'(w_quot) + w_offset;
                    n_state = S_M1;
                end
            end
            S_M1: begin
                n_state = S_A1;
            end
            S_A1: begin
                n_lp1   = BW'(r_last_lp) + w_rnd[BW-1:0];
                n_state = S_M2;
            end
            S_M2: begin
                n_state = S_A2;
            end
            S_A2: begin
                if (w_rnd > w_hi) begin
                    n_lp   = w_hi[ST-1:0];
                    n_clip = 1'b1;
                end else if (w_rnd < w_lo) begin
                    n_lp   = w_lo[ST-1:0];
                    n_clip = 1'b1;
                end else begin
                    n_lp = w_rnd[ST-1:0];
                end
                if (r_hp_enable) begin
                    n_state = S_M3;
                end else begin
                    n_hp    = n_lp;
                    n_state = S_DONE;
                end
            end
            S_M3: begin
                n_state = S_A3;
            end
            S_A3: begin
                if (w_hp_sum > w_hi) begin
                    n_hp   = w_hi[ST-1:0];
                    n_clip = 1'b1;
                end else if (w_hp_sum < w_lo) begin
                    n_hp   = w_lo[ST-1:0];
                    n_clip = 1'b1;
                end else begin
                    n_hp = w_hp_sum[ST-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = w_hp_out;
                    n_out_clip   = r_clip;
                    n_last_lp    = r_lp;
                    n_last_out   = r_hp;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_last_lp     <= '0;
            r_last_out    <= '0;
            r_filter_mode <= 1'b0;
            r_hp_enable   <= 1'b0;
            r_gain_offset <= '0;
            r_hp_coeff    <= lpg_pkg::HPC_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last_lp   <= n_last_lp;
            r_last_out  <= n_last_out;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    lpg_pkg::CFG_FILTER_MODE:     r_filter_mode <= i_cfg.data[0];
                    lpg_pkg::CFG_HIGHPASS_ENABLE: r_hp_enable   <= i_cfg.data[0];
                    lpg_pkg::CFG_GAIN_OFFSET:     r_gain_offset <= i_cfg.data;
                    lpg_pkg::CFG_HIGHPASS_COEFF:  r_hp_coeff    <= i_cfg.data[lpg_pkg::HPC_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x          <= n_x;
        r_coef       <= n_coef;
        r_gain       <= n_gain;
        r_lp1        <= n_lp1;
        r_lp         <= n_lp;
        r_hp         <= n_hp;
        r_clip       <= n_clip;
        r_out_sample <= n_out_sample;
        r_out_clip   <= n_out_clip;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.clipped    = r_out_clip;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in.ready)
        else $error("input ready while an item is in work");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == S_DONE))
        else $error("result appeared without a finished item");

endmodule
